// ----- src/bfs_nhf_pkg.sv -----
// Shared types and constants for the BFS next-hop finder.
// Holds the controller state and datapath command encodings and the status struct.
// No dependencies.
package bfs_nhf_pkg;

    // Default number of nodes held in the link matrix
    localparam int NODES_DEF = 32;

    // Field widths
    localparam int IDX_W  = 5;
    localparam int NCNT_W = 6;

    // Reset value of the node count register
    localparam logic [NCNT_W-1:0] NCNT_RST = 6'd32;

    // Action code of an add input item
    localparam logic ACTION_ADD = 1'b0;

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LINK_WR,
        ST_GOAL,
        ST_DEQ,
        ST_CUR,
        ST_ROW,
        ST_SCAN,
        ST_C_INIT,
        ST_C_RD,
        ST_C_CMP,
        ST_RESULT
    } ctrl_state_t;

    // Datapath commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LINK_RD,
        OP_LINK_WR,
        OP_Q_INIT,
        OP_GOAL,
        OP_DEQ,
        OP_CUR,
        OP_ROW,
        OP_SCAN,
        OP_C_INIT,
        OP_C_RD,
        OP_C_CMP,
        OP_RESULT
    } dp_op_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic action;
        logic query_bad;
        logic queue_empty;
        logic is_stop;
        logic scan_done;
        logic goal_has_pred;
        logic chain_hit;
        logic chain_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- src/bfs_nhf_ctrl.sv -----
// Controller state machine of the BFS next-hop finder.
// Sequences link adds, the search, the predecessor chain walk and result delivery.
// Depends on bfs_nhf_pkg.
module bfs_nhf_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  bfs_nhf_pkg::dp_status_t status,
    output bfs_nhf_pkg::dp_op_t     op
);

    bfs_nhf_pkg::ctrl_state_t state_reg;
    bfs_nhf_pkg::ctrl_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bfs_nhf_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Pick the next state and the datapath command
    always_comb
    begin
        state_next = state_reg;
        op         = bfs_nhf_pkg::OP_NONE;
        in_ready   = 1'b0;
        case (state_reg)
            bfs_nhf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op         = bfs_nhf_pkg::OP_ACCEPT;
                    state_next = bfs_nhf_pkg::ST_DISPATCH;
                end
            end
            bfs_nhf_pkg::ST_DISPATCH:
            begin
                if (status.action == bfs_nhf_pkg::ACTION_ADD)
                begin
                    op         = bfs_nhf_pkg::OP_LINK_RD;
                    state_next = bfs_nhf_pkg::ST_LINK_WR;
                end
                else if (status.query_bad)
                begin
                    state_next = bfs_nhf_pkg::ST_RESULT;
                end
                else
                begin
                    op         = bfs_nhf_pkg::OP_Q_INIT;
                    state_next = bfs_nhf_pkg::ST_GOAL;
                end
            end
            bfs_nhf_pkg::ST_LINK_WR:
            begin
                op         = bfs_nhf_pkg::OP_LINK_WR;
                state_next = bfs_nhf_pkg::ST_IDLE;
            end
            bfs_nhf_pkg::ST_GOAL:
            begin
                op         = bfs_nhf_pkg::OP_GOAL;
                state_next = bfs_nhf_pkg::ST_DEQ;
            end
            bfs_nhf_pkg::ST_DEQ:
            begin
                if (status.queue_empty)
                begin
                    state_next = status.goal_has_pred ? bfs_nhf_pkg::ST_C_INIT
                                                      : bfs_nhf_pkg::ST_RESULT;
                end
                else
                begin
                    op         = bfs_nhf_pkg::OP_DEQ;
                    state_next = bfs_nhf_pkg::ST_CUR;
                end
            end
            bfs_nhf_pkg::ST_CUR:
            begin
                op         = bfs_nhf_pkg::OP_CUR;
                state_next = bfs_nhf_pkg::ST_ROW;
            end
            bfs_nhf_pkg::ST_ROW:
            begin
                op         = bfs_nhf_pkg::OP_ROW;
                state_next = status.is_stop ? bfs_nhf_pkg::ST_C_INIT : bfs_nhf_pkg::ST_SCAN;
            end
            bfs_nhf_pkg::ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    state_next = bfs_nhf_pkg::ST_DEQ;
                end
                else
                begin
                    op = bfs_nhf_pkg::OP_SCAN;
                end
            end
            bfs_nhf_pkg::ST_C_INIT:
            begin
                op         = bfs_nhf_pkg::OP_C_INIT;
                state_next = bfs_nhf_pkg::ST_C_RD;
            end
            bfs_nhf_pkg::ST_C_RD:
            begin
                op         = bfs_nhf_pkg::OP_C_RD;
                state_next = bfs_nhf_pkg::ST_C_CMP;
            end
            bfs_nhf_pkg::ST_C_CMP:
            begin
                op = bfs_nhf_pkg::OP_C_CMP;
                if (status.chain_hit || status.chain_last)
                begin
                    state_next = bfs_nhf_pkg::ST_RESULT;
                end
                else
                begin
                    state_next = bfs_nhf_pkg::ST_C_RD;
                end
            end
            bfs_nhf_pkg::ST_RESULT:
            begin
                if (status.out_free)
                begin
                    op         = bfs_nhf_pkg::OP_RESULT;
                    state_next = bfs_nhf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfs_nhf_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/bfs_nhf_dpath.sv -----
// Datapath of the BFS next-hop finder: link memories, queue, predecessor table,
// visited marks, scan counters and the output register.
// Depends on bfs_nhf_pkg.
module bfs_nhf_dpath #(
    parameter int NODES = bfs_nhf_pkg::NODES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [bfs_nhf_pkg::NCNT_W-1:0]   cfg_wr_data,
    input  logic                             action,
    input  logic [bfs_nhf_pkg::IDX_W-1:0]    link_tail,
    input  logic [bfs_nhf_pkg::IDX_W-1:0]    link_head,
    input  logic [bfs_nhf_pkg::IDX_W-1:0]    path_start,
    input  logic [bfs_nhf_pkg::IDX_W-1:0]    path_goal,
    input  bfs_nhf_pkg::dp_op_t              op,
    output bfs_nhf_pkg::dp_status_t          status,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             found,
    output logic [bfs_nhf_pkg::IDX_W-1:0]    next_node
);

    localparam int NW = $clog2(NODES);
    localparam int CW = NW + 1;
    localparam int IW = bfs_nhf_pkg::IDX_W;
    localparam logic [CW-1:0]    NODES_C = CW'(NODES);
    localparam logic [NW-1:0]    LAST_K  = NW'(NODES - 1);
    localparam logic [NODES-1:0] ONE_LSB = {{(NODES-1){1'b0}}, 1'b1};

    // Memories
    logic [NODES-1:0] fwd_mem   [NODES];
    logic [NODES-1:0] rev_mem   [NODES];
    logic [NW-1:0]    queue_mem [NODES];
    logic [NW-1:0]    pred_mem  [NODES];

    // Control registers
    logic [bfs_nhf_pkg::NCNT_W-1:0] node_count_reg;
    logic [NODES-1:0] fwd_vld_reg;
    logic [NODES-1:0] rev_vld_reg;
    logic             fwd_ok_reg;
    logic             rev_ok_reg;
    logic [NODES-1:0] visited_reg;
    logic [CW-1:0]    head_reg;
    logic [CW-1:0]    tail_reg;
    logic [CW-1:0]    scan_i_reg;
    logic [NW-1:0]    k_reg;
    logic             ghp_reg;
    logic             out_valid_reg;

    // Payload registers
    logic             action_reg;
    logic [IW-1:0]    link_tail_reg;
    logic [IW-1:0]    link_head_reg;
    logic [IW-1:0]    path_start_reg;
    logic [IW-1:0]    path_goal_reg;
    logic [NODES-1:0] fwd_rd_reg;
    logic [NODES-1:0] rev_rd_reg;
    logic [NW-1:0]    queue_rd_reg;
    logic [NW-1:0]    pred_rd_reg;
    logic [NODES-1:0] goal_row_reg;
    logic [NODES-1:0] adj_reg;
    logic [NW-1:0]    cur_reg;
    logic [NW-1:0]    x_reg;
    logic             found_reg;
    logic [IW-1:0]    next_node_reg;

    // Combinational signals
    logic [NW-1:0]    tail_idx;
    logic [NW-1:0]    head_idx;
    logic [NW-1:0]    s_idx;
    logic [NW-1:0]    t_idx;
    logic [NW-1:0]    i_idx;
    logic             link_ok;
    logic             query_bad;
    logic [NODES-1:0] fwd_row;
    logic [NODES-1:0] rev_row;
    logic [NW-1:0]    fwd_addr;
    logic [NW-1:0]    rev_addr;
    logic             fwd_rd_en;
    logic             rev_rd_en;
    logic             link_wr_en;
    logic             scan_done;
    logic             is_stop;
    logic             take;
    logic             q_wr_en;
    logic [NW-1:0]    q_wr_addr;
    logic [NW-1:0]    q_wr_data;
    logic             pred_wr_en;
    logic [NW-1:0]    pred_wr_addr;
    logic             chain_hit;

    // Decode latched item fields
    assign tail_idx  = NW'(link_tail_reg);
    assign head_idx  = NW'(link_head_reg);
    assign s_idx     = NW'(path_start_reg);
    assign t_idx     = NW'(path_goal_reg);
    assign i_idx     = scan_i_reg[NW-1:0];
    assign link_ok   = (32'(link_tail_reg) < NODES) && (32'(link_head_reg) < NODES);
    assign query_bad = !((32'(path_start_reg) < NODES) && (32'(path_goal_reg) < NODES));

    // Rows never written read as empty
    assign fwd_row = fwd_ok_reg ? fwd_rd_reg : '0;
    assign rev_row = rev_ok_reg ? rev_rd_reg : '0;

    // Select link memory read addresses
    always_comb
    begin
        fwd_addr = t_idx;
        rev_addr = head_idx;
        case (op)
            bfs_nhf_pkg::OP_LINK_RD:
            begin
                fwd_addr = tail_idx;
            end
            bfs_nhf_pkg::OP_CUR:
            begin
                fwd_addr = queue_rd_reg;
                rev_addr = queue_rd_reg;
            end
            default:
            begin
                fwd_addr = t_idx;
            end
        endcase
    end

    assign fwd_rd_en  = op inside {bfs_nhf_pkg::OP_LINK_RD, bfs_nhf_pkg::OP_Q_INIT,
                                   bfs_nhf_pkg::OP_CUR};
    assign rev_rd_en  = op inside {bfs_nhf_pkg::OP_LINK_RD, bfs_nhf_pkg::OP_CUR};
    assign link_wr_en = (op == bfs_nhf_pkg::OP_LINK_WR) && link_ok;

    // Neighbor scan and stop test
    assign scan_done = (scan_i_reg == NODES_C) ||
                       (32'(scan_i_reg) >= 32'(node_count_reg));
    assign is_stop   = goal_row_reg[cur_reg];
    assign take      = (op == bfs_nhf_pkg::OP_SCAN) && !scan_done &&
                       adj_reg[i_idx] && !visited_reg[i_idx];

    // Queue write port
    assign q_wr_en   = (op == bfs_nhf_pkg::OP_Q_INIT) || (take && (tail_reg < NODES_C));
    assign q_wr_addr = (op == bfs_nhf_pkg::OP_Q_INIT) ? '0 : tail_reg[NW-1:0];
    assign q_wr_data = (op == bfs_nhf_pkg::OP_Q_INIT) ? s_idx : i_idx;

    // Predecessor write port
    assign pred_wr_en   = take || ((op == bfs_nhf_pkg::OP_ROW) && is_stop);
    assign pred_wr_addr = (op == bfs_nhf_pkg::OP_ROW) ? t_idx : i_idx;

    assign chain_hit = (pred_rd_reg == s_idx);

    // Link memories, read registered
    always_ff @(posedge clk)
    begin
        if (fwd_rd_en)
        begin
            fwd_rd_reg <= fwd_mem[fwd_addr];
        end
        if (rev_rd_en)
        begin
            rev_rd_reg <= rev_mem[rev_addr];
        end
        if (link_wr_en)
        begin
            fwd_mem[tail_idx] <= fwd_row | (ONE_LSB << head_idx);
            rev_mem[head_idx] <= rev_row | (ONE_LSB << tail_idx);
        end
    end

    // Search queue
    always_ff @(posedge clk)
    begin
        if (op == bfs_nhf_pkg::OP_DEQ)
        begin
            queue_rd_reg <= queue_mem[head_reg[NW-1:0]];
        end
        if (q_wr_en)
        begin
            queue_mem[q_wr_addr] <= q_wr_data;
        end
    end

    // Predecessor table
    always_ff @(posedge clk)
    begin
        if (op == bfs_nhf_pkg::OP_C_RD)
        begin
            pred_rd_reg <= pred_mem[x_reg];
        end
        if (pred_wr_en)
        begin
            pred_mem[pred_wr_addr] <= cur_reg;
        end
    end

    // Control state: row valid flags, counters, marks, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= bfs_nhf_pkg::NCNT_RST;
            fwd_vld_reg    <= '0;
            rev_vld_reg    <= '0;
            fwd_ok_reg     <= 1'b0;
            rev_ok_reg     <= 1'b0;
            visited_reg    <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            scan_i_reg     <= '0;
            k_reg          <= '0;
            ghp_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
            if (fwd_rd_en)
            begin
                fwd_ok_reg <= fwd_vld_reg[fwd_addr];
            end
            if (rev_rd_en)
            begin
                rev_ok_reg <= rev_vld_reg[rev_addr];
            end
            if (link_wr_en)
            begin
                fwd_vld_reg[tail_idx] <= 1'b1;
                rev_vld_reg[head_idx] <= 1'b1;
            end

            case (op)
                bfs_nhf_pkg::OP_ACCEPT:
                begin
                    ghp_reg <= 1'b0;
                end
                bfs_nhf_pkg::OP_Q_INIT:
                begin
                    visited_reg <= ONE_LSB << s_idx;
                    head_reg    <= '0;
                    tail_reg    <= CW'(1);
                end
                bfs_nhf_pkg::OP_DEQ:
                begin
                    head_reg <= head_reg + CW'(1);
                end
                bfs_nhf_pkg::OP_ROW:
                begin
                    scan_i_reg <= '0;
                    if (is_stop)
                    begin
                        ghp_reg <= 1'b1;
                    end
                end
                bfs_nhf_pkg::OP_SCAN:
                begin
                    scan_i_reg <= scan_i_reg + CW'(1);
                    if (take)
                    begin
                        visited_reg[i_idx] <= 1'b1;
                        if (tail_reg < NODES_C)
                        begin
                            tail_reg <= tail_reg + CW'(1);
                        end
                        if (i_idx == t_idx)
                        begin
                            ghp_reg <= 1'b1;
                        end
                    end
                end
                bfs_nhf_pkg::OP_C_INIT:
                begin
                    k_reg <= '0;
                end
                bfs_nhf_pkg::OP_C_CMP:
                begin
                    if (!chain_hit)
                    begin
                        k_reg <= k_reg + NW'(1);
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase

            // Load the result, or drop it once taken
            if (op == bfs_nhf_pkg::OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (op)
            bfs_nhf_pkg::OP_ACCEPT:
            begin
                action_reg     <= action;
                link_tail_reg  <= link_tail;
                link_head_reg  <= link_head;
                path_start_reg <= path_start;
                path_goal_reg  <= path_goal;
            end
            bfs_nhf_pkg::OP_GOAL:
            begin
                goal_row_reg <= fwd_row;
            end
            bfs_nhf_pkg::OP_CUR:
            begin
                cur_reg <= queue_rd_reg;
            end
            bfs_nhf_pkg::OP_ROW:
            begin
                adj_reg <= fwd_row | rev_row;
            end
            bfs_nhf_pkg::OP_C_INIT:
            begin
                x_reg <= t_idx;
            end
            bfs_nhf_pkg::OP_C_CMP:
            begin
                if (!chain_hit)
                begin
                    x_reg <= pred_rd_reg;
                end
            end
            bfs_nhf_pkg::OP_RESULT:
            begin
                found_reg     <= ghp_reg;
                next_node_reg <= ghp_reg ? IW'(x_reg) : '0;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    // Status to the controller
    always_comb
    begin
        status.action        = action_reg;
        status.query_bad     = query_bad;
        status.queue_empty   = (head_reg == tail_reg);
        status.is_stop       = is_stop;
        status.scan_done     = scan_done;
        status.goal_has_pred = ghp_reg;
        status.chain_hit     = chain_hit;
        status.chain_last    = (k_reg == LAST_K);
        status.out_free      = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign next_node = next_node_reg;

`ifndef ASSERT_OFF
    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= NODES_C)
        else $error("queue tail beyond node count");

    a_deq_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (op == bfs_nhf_pkg::OP_DEQ) |-> (head_reg < tail_reg))
        else $error("dequeue from empty queue");

    a_visited_count: assert property (@(posedge clk) disable iff (!rst_n)
        (op == bfs_nhf_pkg::OP_DEQ) |-> ($countones(visited_reg) == 32'(tail_reg)))
        else $error("visited marks disagree with queue fill");

    a_chain_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (op == bfs_nhf_pkg::OP_C_RD) |-> (32'(x_reg) < NODES))
        else $error("chain walk index out of range");
`endif

endmodule

// ----- src/bfs_next_hop_finder_top.sv -----
// Add-link item: accepted, then passes the dispatch and link write states before the next item is taken; no result.
// Query item: the search dequeues at most NODES nodes and scans min(node_count, NODES)
// neighbors of each, one node per cycle; the predecessor chain walk then reads at most NODES
// entries before the result register is loaded; one item at a time.
// Reset (rst_n, async, active low) empties the link matrix through per-row valid flags at once,
// sets node_count to 32 and drops any pending result; there is no clearing pass.
module bfs_next_hop_finder_top #(
    parameter int NODES = bfs_nhf_pkg::NODES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bfs_nhf_pkg::NCNT_W-1:0] cfg_wr_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [bfs_nhf_pkg::IDX_W-1:0]  link_tail,
    input  logic [bfs_nhf_pkg::IDX_W-1:0]  link_head,
    input  logic [bfs_nhf_pkg::IDX_W-1:0]  path_start,
    input  logic [bfs_nhf_pkg::IDX_W-1:0]  path_goal,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           found,
    output logic [bfs_nhf_pkg::IDX_W-1:0]  next_node
);

    bfs_nhf_pkg::dp_op_t     op;
    bfs_nhf_pkg::dp_status_t status;

    // Sequence the search
    bfs_nhf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .op       (op)
    );

    // Hold the graph and the search state
    bfs_nhf_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .action      (action),
        .link_tail   (link_tail),
        .link_head   (link_head),
        .path_start  (path_start),
        .path_goal   (path_goal),
        .op          (op),
        .status      (status),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .next_node   (next_node)
    );

endmodule

// ----- sim/bfs_next_hop_finder_top_test.sv -----
// Self-checking testbench for bfs_next_hop_finder_top: link adds and next-hop queries.
// A scoreboard class predicts each query's answer by its own breadth-first search.
// Depends on bfs_nhf_pkg and bfs_next_hop_finder_top.
module bfs_next_hop_finder_top_test;

    localparam int   IW             = bfs_nhf_pkg::IDX_W;
    localparam int   CNW            = bfs_nhf_pkg::NCNT_W;
    localparam logic ACTION_QUERY   = ~bfs_nhf_pkg::ACTION_ADD;
    localparam int   MAX_NODES      = bfs_nhf_pkg::NODES_DEF;
    localparam int   STALL_CYCLES   = 400;
    localparam int   SETTLE_CYCLES  = 8;
    localparam int   END_CYCLES     = 60;
    localparam int   WATCHDOG_LIMIT = 20000;
    localparam int   PHASE_ITEMS    = 74;

    typedef struct packed {
        logic           found;
        logic [IW-1:0]  hop;
    } hop_result_t;

    // Predicts next hops from its own copy of the links and node count
    class next_hop_scoreboard;
        logic [MAX_NODES-1:0] links [MAX_NODES];
        logic [IW-1:0]        pred [MAX_NODES];
        int unsigned          node_limit;
        hop_result_t          pending [$];
        int                   errors;

        function new();
            for (int i = 0; i < MAX_NODES; i++)
            begin
                links[i] = '0;
                pred[i]  = '0;
            end
            node_limit = 32'(bfs_nhf_pkg::NCNT_RST);
            errors     = 0;
        endfunction

        function void set_node_count(logic [CNW-1:0] value);
            node_limit = 32'(value);
        endfunction

        // Search from s over links in either direction; stop on a link t->current
        function hop_result_t find_next_hop(logic [IW-1:0] s, logic [IW-1:0] t);
            logic [MAX_NODES-1:0] seen;
            logic [IW-1:0]        fifo [MAX_NODES];
            int                   head;
            int                   tail;
            int                   lim;
            int                   cur;
            int                   x;
            logic                 goal_pred;
            hop_result_t          r;
            lim       = (node_limit < MAX_NODES) ? node_limit : MAX_NODES;
            goal_pred = 1'b0;
            seen      = '0;
            seen[s]   = 1'b1;
            fifo[0]   = s;
            head      = 0;
            tail      = 1;
            while (head < tail)
            begin
                cur  = int'(fifo[head]);
                head = head + 1;
                if (links[t][cur])
                begin
                    pred[t]   = IW'(cur);
                    goal_pred = 1'b1;
                    break;
                end
                for (int i = 0; i < lim; i++)
                begin
                    if ((links[cur][i] || links[i][cur]) && !seen[i])
                    begin
                        if (tail < MAX_NODES)
                        begin
                            fifo[tail] = IW'(i);
                            tail = tail + 1;
                        end
                        seen[i] = 1'b1;
                        pred[i] = IW'(cur);
                        if (i == t)
                            goal_pred = 1'b1;
                    end
                end
            end
            r = '0;
            if (goal_pred)
            begin
                // Walk back until the node whose predecessor is the start
                x = int'(t);
                for (int k = 0; k < MAX_NODES; k++)
                begin
                    if (pred[x] == s)
                        break;
                    x = int'(pred[x]);
                end
                r.found = 1'b1;
                r.hop   = IW'(x);
            end
            return r;
        endfunction

        // Record an accepted item: apply an add, or queue the query's answer
        function void note_item(logic act, logic [IW-1:0] a, logic [IW-1:0] b);
            if (act == bfs_nhf_pkg::ACTION_ADD)
                links[a][b] = 1'b1;
            else
                pending.insert(pending.size(), find_next_hop(a, b));
        endfunction

        // Compare a delivered result with the oldest expected one
        function void check_result(logic f, logic [IW-1:0] n);
            hop_result_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: result with none expected: found=%0b next_node=%0d",
                         $time, f, n);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (f !== e.found)
            begin
                $display("%0t: found mismatch: expected %0b actual %0b", $time, e.found, f);
                errors++;
            end
            if (n !== e.hop)
            begin
                $display("%0t: next_node mismatch: expected %0d actual %0d",
                         $time, e.hop, n);
                errors++;
            end
        endfunction
    endclass

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            cfg_wr_en = 1'b0;
    logic [CNW-1:0]  cfg_wr_data = '0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic            action = bfs_nhf_pkg::ACTION_ADD;
    logic [IW-1:0]   link_tail = '0;
    logic [IW-1:0]   link_head = '0;
    logic [IW-1:0]   path_start = '0;
    logic [IW-1:0]   path_goal = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic            found;
    logic [IW-1:0]   next_node;

    next_hop_scoreboard sb = new();
    bit                 quiet = 1'b0;
    int                 stall_reqs = 0;
    int                 stall_seen = 0;
    int                 idle_cycles = 0;

    bfs_next_hop_finder_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .link_tail  (link_tail),
        .link_head  (link_head),
        .path_start (path_start),
        .path_goal  (path_goal),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .found      (found),
        .next_node  (next_node)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Offer one item, with an occasional gap first; hold it until accepted
    task automatic send_item(logic act, logic [IW-1:0] a, logic [IW-1:0] b);
        if (!quiet && $urandom_range(99) < 8)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        if (act == bfs_nhf_pkg::ACTION_ADD)
        begin
            link_tail  <= a;
            link_head  <= b;
            path_start <= IW'($urandom_range(31));
            path_goal  <= IW'($urandom_range(31));
        end
        else
        begin
            path_start <= a;
            path_goal  <= b;
            link_tail  <= IW'($urandom_range(31));
            link_head  <= IW'($urandom_range(31));
        end
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_item(act, a, b);
    endtask

    // Drop valid and wait until every expected result is back and an add has settled
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_node_count(logic [CNW-1:0] value);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_node_count(value);
    endtask

    // Accept results, idling at random or holding off for a long stretch on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_reqs != stall_seen)
            begin
                stall_seen = stall_reqs;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            out_ready <= quiet || ($urandom_range(99) >= 8);
        end
    end

    // Check each delivered result
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(found, next_node);
    end

    // End the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [CNW-1:0] phase_ncnt [7];
        logic [CNW-1:0] ncnt;
        logic [IW-1:0]  a;
        logic [IW-1:0]  b;
        phase_ncnt = '{6'd32, 6'd1, 6'd2, 6'd8, 6'd16, 6'd0, 6'd32};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty graph, self link, short chain, stop at the start
        send_item(ACTION_QUERY, 5'd0, 5'd0);
        send_item(ACTION_QUERY, 5'd31, 5'd0);
        send_item(bfs_nhf_pkg::ACTION_ADD, 5'd31, 5'd31);
        send_item(ACTION_QUERY, 5'd31, 5'd31);
        send_item(bfs_nhf_pkg::ACTION_ADD, 5'd0, 5'd1);
        send_item(bfs_nhf_pkg::ACTION_ADD, 5'd1, 5'd2);
        send_item(ACTION_QUERY, 5'd0, 5'd2);
        send_item(bfs_nhf_pkg::ACTION_ADD, 5'd2, 5'd0);
        send_item(ACTION_QUERY, 5'd0, 5'd2);
        send_item(ACTION_QUERY, 5'd2, 5'd0);
        send_item(bfs_nhf_pkg::ACTION_ADD, 5'd5, 5'd30);
        send_item(ACTION_QUERY, 5'd30, 5'd5);

        // Smallest node count: queries with the goal above it
        write_node_count(6'd1);
        send_item(ACTION_QUERY, 5'd0, 5'd2);
        send_item(ACTION_QUERY, 5'd30, 5'd5);
        send_item(ACTION_QUERY, 5'd1, 5'd2);

        // Goal just outside the node count, reached only through its own links
        write_node_count(6'd31);
        send_item(ACTION_QUERY, 5'd0, 5'd31);
        send_item(bfs_nhf_pkg::ACTION_ADD, 5'd31, 5'd3);
        send_item(bfs_nhf_pkg::ACTION_ADD, 5'd3, 5'd2);
        send_item(ACTION_QUERY, 5'd0, 5'd31);
        send_item(ACTION_QUERY, 5'd31, 5'd0);
        send_item(bfs_nhf_pkg::ACTION_ADD, 5'd21, 5'd10);

        // Random phases, one node count each
        for (int ph = 0; ph < 7; ph++)
        begin
            ncnt = (phase_ncnt[ph] == 0) ? CNW'($urandom_range(3, 31)) : phase_ncnt[ph];
            write_node_count(ncnt);
            quiet = (ph == 2);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (ph == 3 && n == 20)
                    stall_reqs++;
                if (ph == 4 && n == 37)
                    wait_drain();
                if ($urandom_range(99) < 28)
                begin
                    a = IW'($urandom_range(1) ? $urandom_range(ncnt - 1) : $urandom_range(31));
                    b = IW'($urandom_range(1) ? $urandom_range(ncnt - 1) : $urandom_range(31));
                    send_item(bfs_nhf_pkg::ACTION_ADD, a, b);
                end
                else
                begin
                    a = IW'($urandom_range(3) != 0 ? $urandom_range(ncnt - 1)
                                                   : $urandom_range(31));
                    b = IW'($urandom_range(3) != 0 ? $urandom_range(ncnt - 1)
                                                   : $urandom_range(31));
                    send_item(ACTION_QUERY, a, b);
                end
            end
            quiet = 1'b0;
        end

        // Drain, then allow for any stray result
        wait_drain();
        repeat (END_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
src/bfs_nhf_pkg.sv
src/bfs_nhf_ctrl.sv
src/bfs_nhf_dpath.sv
src/bfs_next_hop_finder_top.sv
sim/bfs_next_hop_finder_top_test.sv
